// ===== hdl/key_repeat_and_char_translate_macros.svh =====
// Assertion macros for the key repeat and character translate block
`ifndef KEY_REPEAT_AND_CHAR_TRANSLATE_MACROS_SVH
`define KEY_REPEAT_AND_CHAR_TRANSLATE_MACROS_SVH
`ifndef NO_ASSERTIONS
// cons must hold in the same cycle as ante
`define KRCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("krct assertion failed");
// cons must hold in the cycle after ante
`define KRCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("krct assertion failed");
`else
`define KRCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KRCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/krct_pkg.sv =====
// Shared types and constants of the key repeat and character translate block
package krct_pkg;

	localparam int KEY_CODES   = 256;
	localparam int KAW         = $clog2(KEY_CODES);
	localparam int QUEUE_DEPTH = 64;
	localparam int QAW         = $clog2(QUEUE_DEPTH);
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_OUT     = 63;
	localparam int OUT_CW      = $clog2(MAX_OUT + 1);
	localparam int TIME_W      = 63;

	localparam int PADDR_W = 5;
	localparam int REG_AW  = 3;

	localparam logic [REG_AW-1:0] REG_HOLD_LIMIT   = 3'd0;
	localparam logic [REG_AW-1:0] REG_RPT_PERIOD   = 3'd1;
	localparam logic [REG_AW-1:0] REG_QUEUE_LIMIT  = 3'd2;
	localparam logic [REG_AW-1:0] REG_LETTER_BASE  = 3'd3;
	localparam logic [REG_AW-1:0] REG_DIGIT_BASE   = 3'd4;
	localparam logic [REG_AW-1:0] REG_SHIFT_LEFT   = 3'd5;
	localparam logic [REG_AW-1:0] REG_SHIFT_RIGHT  = 3'd6;

	localparam logic [31:0] RST_HOLD_LIMIT   = 32'd1000000000;
	localparam logic [31:0] RST_RPT_PERIOD   = 32'd300000000;
	localparam logic [5:0]  RST_QUEUE_LIMIT  = 6'd62;
	localparam logic [7:0]  RST_LETTER_BASE  = 8'd29;
	localparam logic [7:0]  RST_DIGIT_BASE   = 8'd7;
	localparam logic [7:0]  RST_SHIFT_LEFT   = 8'd59;
	localparam logic [7:0]  RST_SHIFT_RIGHT  = 8'd60;

	localparam logic       FUNC_KEY   = 1'b0;
	localparam logic       FUNC_DRAIN = 1'b1;
	localparam logic [1:0] ACT_PRESS  = 2'd0;
	localparam logic       CMD_KEY    = 1'b0;
	localparam logic       CMD_DRAIN  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [7:0]        key_code;
		logic [1:0]        key_action;
		logic [TIME_W-1:0] event_time;
	} req_t;

	typedef struct packed {
		logic [6:0] character;
		logic       char_valid;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] hold_limit;
		logic [31:0] rpt_period;
		logic [5:0]  queue_limit;
		logic [7:0]  letter_base;
		logic [7:0]  digit_base;
		logic [7:0]  shift_left_code;
		logic [7:0]  shift_right_code;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic              is_press;
		logic [7:0]        key_code;
		logic [1:0]        key_action;
		logic [TIME_W-1:0] event_time;
	} cmd_t;

	typedef struct packed {
		logic           drain_done;
		logic [QCW-1:0] q_count;
	} st_t;

endpackage

// ===== hdl/krct_front.sv =====
// Front end: accept transactions, classify them and hold them in a short command queue
module krct_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  krct_pkg::req_t  req,
	output logic            req_ready,
	output logic            cmd_valid,
	output krct_pkg::cmd_t  cmd,
	input  logic            cmd_ready
);

	localparam int CQ_DEPTH = 2;

	krct_pkg::cmd_t fifo_q [CQ_DEPTH];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	krct_pkg::cmd_t cmd_in;
	logic           keep;
	logic           push;
	logic           pop;

	// drop key events whose code falls outside the table
	always_comb begin
		keep = (req.func == krct_pkg::FUNC_DRAIN) || (32'(req.key_code) < krct_pkg::KEY_CODES);
		cmd_in.kind       = (req.func == krct_pkg::FUNC_DRAIN) ? krct_pkg::CMD_DRAIN
		                                                       : krct_pkg::CMD_KEY;
		cmd_in.is_press   = (req.key_action == krct_pkg::ACT_PRESS);
		cmd_in.key_code   = req.key_code;
		cmd_in.key_action = req.key_action;
		cmd_in.event_time = req.event_time;
	end

	assign req_ready = (32'(cnt_q) < CQ_DEPTH);
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_q];
	assign push      = req_valid && req_ready && keep;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/krct_out_buf.sv =====
// Two-entry result buffer between the back end and the result channel
module krct_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fill_valid,
	input  krct_pkg::rsp_t  fill,
	output logic            fill_ready,
	output logic            rsp_valid,
	output krct_pkg::rsp_t  rsp,
	input  logic            rsp_ready
);

	localparam int OB_DEPTH = 2;

	krct_pkg::rsp_t buf_q [OB_DEPTH];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign fill_ready = (32'(cnt_q) < OB_DEPTH);
	assign rsp_valid  = (cnt_q != '0);
	assign rsp        = buf_q[rd_q];
	assign push       = fill_valid && fill_ready;
	assign pop        = rsp_valid && rsp_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/krct_back.sv =====
// Back end: per-key repeat table, code queue and drain translator
module krct_back (
	input  logic            clk,
	input  logic            arst_n,
	input  krct_pkg::cfg_t  cfg,
	input  logic            cmd_valid,
	input  krct_pkg::cmd_t  cmd,
	output logic            cmd_ready,
	output logic            emit_valid,
	output krct_pkg::rsp_t  emit,
	input  logic            emit_ready,
	output krct_pkg::st_t   st
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_KEY_DIFF = 3'd1;
	localparam logic [2:0] ST_KEY_UPD  = 3'd2;
	localparam logic [2:0] ST_DR_EVAL  = 3'd3;
	localparam logic [2:0] ST_DR_END   = 3'd4;

	localparam logic [8:0] LETTER_SPAN = 9'd25;
	localparam logic [8:0] DIGIT_SPAN  = 9'd9;
	localparam logic [6:0] ASCII_LOW_A = 7'h61;
	localparam logic [6:0] ASCII_UP_A  = 7'h41;
	localparam logic [6:0] ASCII_ZERO  = 7'h30;

	typedef struct packed {
		logic [1:0]                  action;
		logic [krct_pkg::TIME_W-1:0] stamp;
		logic [31:0]                 held;
		logic [31:0]                 rpt;
	} krec_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic logic [6:0] shifted_digit(input logic [3:0] d);
		logic [6:0] r;
		case (d)
			4'd0:    r = 7'h29;  // )
			4'd1:    r = 7'h21;  // !
			4'd2:    r = 7'h40;  // @
			4'd3:    r = 7'h23;  // #
			4'd4:    r = 7'h24;  // $
			4'd5:    r = 7'h25;  // %
			4'd6:    r = 7'h5e;  // ^
			4'd7:    r = 7'h26;  // &
			4'd8:    r = 7'h2a;  // *
			4'd9:    r = 7'h28;  // (
			default: r = 7'h00;
		endcase
		return r;
	endfunction

	logic [2:0]                   state_q;
	krct_pkg::cmd_t               cur_q;
	krec_t                        tbl_mem [krct_pkg::KEY_CODES];
	krec_t                        rec_q;
	logic [krct_pkg::KEY_CODES-1:0] seen_q;
	logic                         held_path_q;
	logic [31:0]                  dt_q;
	logic [7:0]                   qmem [krct_pkg::QUEUE_DEPTH];
	logic [7:0]                   code_q;
	logic [krct_pkg::QAW-1:0]     head_q;
	logic [krct_pkg::QCW-1:0]     count_q;
	logic                         pend_q;
	logic                         hv_q;
	logic [6:0]                   hchar_q;
	logic [krct_pkg::OUT_CW-1:0]  nout_q;

	logic [krct_pkg::KAW-1:0]     cmd_idx;
	logic [krct_pkg::KAW-1:0]     cur_idx;
	logic [krct_pkg::TIME_W:0]    diff;
	logic [31:0]                  dt_sat;
	logic [31:0]                  held_sum;
	logic [31:0]                  rpt_sum;
	logic                         rpt_ge;
	logic                         held_ge;
	logic                         push;
	logic                         tbl_re;
	logic                         tbl_we;
	krec_t                        tbl_wdata;
	logic                         q_re;
	logic                         q_we;
	logic [krct_pkg::QCW:0]       tail_sum;
	logic [krct_pkg::QAW-1:0]     tail_idx;
	logic [krct_pkg::QAW-1:0]     head_next;
	logic                         count_zero;
	logic                         over_limit;
	logic [8:0]                   c9;
	logic [8:0]                   lb9;
	logic [8:0]                   db9;
	logic                         is_letter;
	logic                         is_digit;
	logic                         is_shift;
	logic                         produce;
	logic                         accept_char;
	logic [7:0]                   loff;
	logic [7:0]                   doff;
	logic [6:0]                   ch;
	logic                         advance;

	assign cmd_idx = krct_pkg::KAW'(cmd.key_code);
	assign cur_idx = krct_pkg::KAW'(cur_q.key_code);

	// key event arithmetic: elapsed time, then saturating held and repeat times
	always_comb begin
		diff   = {1'b0, cur_q.event_time} - {1'b0, rec_q.stamp};
		dt_sat = diff[krct_pkg::TIME_W] ? '0
		       : ((|diff[krct_pkg::TIME_W-1:32]) ? '1 : diff[31:0]);
		held_sum = sat_add(rec_q.held, dt_q);
		rpt_sum  = sat_add(rec_q.rpt, dt_q);
		rpt_ge   = (rec_q.rpt >= cfg.rpt_period);
		held_ge  = (held_sum >= cfg.hold_limit);
		if (held_path_q) begin
			tbl_wdata.action = rec_q.action;
			tbl_wdata.stamp  = cur_q.event_time;
			tbl_wdata.held   = held_sum;
			tbl_wdata.rpt    = held_ge ? (rpt_ge ? '0 : rpt_sum) : rec_q.rpt;
			push             = held_ge && rpt_ge;
		end else begin
			tbl_wdata.action = cur_q.key_action;
			tbl_wdata.stamp  = cur_q.event_time;
			tbl_wdata.held   = '0;
			tbl_wdata.rpt    = '0;
			push             = !seen_q[cur_idx] || cur_q.is_press;
		end
	end

	// queue pointers
	always_comb begin
		tail_sum = (krct_pkg::QCW+1)'(head_q) + (krct_pkg::QCW+1)'(count_q);
		if (32'(tail_sum) >= krct_pkg::QUEUE_DEPTH) begin
			tail_idx = krct_pkg::QAW'(tail_sum - (krct_pkg::QCW+1)'(krct_pkg::QUEUE_DEPTH));
		end else begin
			tail_idx = krct_pkg::QAW'(tail_sum);
		end
		head_next  = (32'(head_q) == krct_pkg::QUEUE_DEPTH - 1) ? '0 : head_q + 1'b1;
		count_zero = (count_q == '0);
		over_limit = (32'(count_q) > 32'(cfg.queue_limit));
	end

	// drain translation of the code at the head; shift is tested first unless
	// a shift is already pending, in which case a letter or digit takes it
	always_comb begin
		c9        = {1'b0, code_q};
		lb9       = {1'b0, cfg.letter_base};
		db9       = {1'b0, cfg.digit_base};
		is_letter = (c9 >= lb9) && (c9 <= lb9 + LETTER_SPAN);
		is_digit  = (c9 >= db9) && (c9 <= db9 + DIGIT_SPAN);
		is_shift  = (code_q == cfg.shift_left_code) || (code_q == cfg.shift_right_code);
		produce   = (is_letter || is_digit) && (pend_q || !is_shift);
		loff      = code_q - cfg.letter_base;
		doff      = code_q - cfg.digit_base;
		if (is_letter) begin
			ch = (pend_q ? ASCII_UP_A : ASCII_LOW_A) + {2'b00, loff[4:0]};
		end else if (pend_q) begin
			ch = shifted_digit(doff[3:0]);
		end else begin
			ch = ASCII_ZERO + {3'b000, doff[3:0]};
		end
		accept_char = produce && (32'(nout_q) < krct_pkg::MAX_OUT);
	end

	// control strobes and result output
	always_comb begin
		cmd_ready  = (state_q == ST_IDLE);
		tbl_re     = 1'b0;
		tbl_we     = 1'b0;
		q_re       = 1'b0;
		q_we       = 1'b0;
		emit_valid = 1'b0;
		emit       = '0;
		advance    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					tbl_re = (cmd.kind == krct_pkg::CMD_KEY);
					q_re   = (cmd.kind == krct_pkg::CMD_DRAIN) && !count_zero;
				end
			end
			ST_KEY_UPD: begin
				tbl_we = 1'b1;
				q_we   = push && (32'(count_q) < krct_pkg::QUEUE_DEPTH);
			end
			ST_DR_EVAL: begin
				emit_valid      = accept_char && hv_q;
				emit.character  = hchar_q;
				emit.char_valid = 1'b1;
				emit.last       = 1'b0;
				advance         = !(emit_valid && !emit_ready);
				q_re            = advance && !count_zero;
			end
			ST_DR_END: begin
				emit_valid      = 1'b1;
				emit.character  = hv_q ? hchar_q : '0;
				emit.char_valid = hv_q;
				emit.last       = 1'b1;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[cur_idx] <= tbl_wdata;
		end
		if (tbl_re) begin
			rec_q <= tbl_mem[cmd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			qmem[tail_idx] <= cur_q.key_code;
		end
		if (q_re) begin
			code_q <= qmem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cur_q <= cmd;
		end
		if (state_q == ST_KEY_DIFF) begin
			dt_q        <= dt_sat;
			held_path_q <= seen_q[cur_idx] && cur_q.is_press
			               && (rec_q.action == krct_pkg::ACT_PRESS);
		end
		if (advance && accept_char) begin
			hchar_q <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			head_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
			hv_q    <= 1'b0;
			nout_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.kind == krct_pkg::CMD_KEY) begin
							if (over_limit) begin
								head_q  <= '0;
								count_q <= '0;
							end
							state_q <= ST_KEY_DIFF;
						end else begin
							pend_q <= 1'b0;
							hv_q   <= 1'b0;
							nout_q <= '0;
							if (count_zero) begin
								state_q <= ST_DR_END;
							end else begin
								head_q  <= head_next;
								count_q <= count_q - 1'b1;
								state_q <= ST_DR_EVAL;
							end
						end
					end
				end
				ST_KEY_DIFF: begin
					state_q <= ST_KEY_UPD;
				end
				ST_KEY_UPD: begin
					seen_q[cur_idx] <= 1'b1;
					if (q_we) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_DR_EVAL: begin
					if (advance) begin
						pend_q <= is_shift && !produce;
						if (accept_char) begin
							hv_q   <= 1'b1;
							nout_q <= nout_q + 1'b1;
						end
						if (count_zero) begin
							state_q <= ST_DR_END;
						end else begin
							head_q  <= head_next;
							count_q <= count_q - 1'b1;
						end
					end
				end
				ST_DR_END: begin
					if (emit_ready) begin
						head_q  <= '0;
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign st.drain_done = (state_q == ST_DR_END) && emit_ready;
	assign st.q_count    = count_q;

endmodule

// ===== hdl/key_repeat_and_char_translate.sv =====
// Top level of the key repeat and character translate block
//
// Key events and drain requests enter on the req channel and land in a
// two-entry command queue, so the source can keep sending while the back end
// works. A key event passes through the idle, diff and update states: the per-key
// record is read from a single-port table memory, the elapsed time is formed
// from it, and the saturating held/repeat update, threshold compare, table
// write-back and optional code push finish in the update state. A drain
// starts in idle, then evaluates the queued codes one at a time (one code-queue
// read per cycle while the result buffer accepts), then sends the closing
// result; the final result of each drain carries last, and a drain that
// yields no character returns a single empty result. Results pass through a
// two-entry buffer before the rsp port. The seen map lives in flip-flops and
// is cleared by reset, so no clearing pass follows reset. Configuration goes
// through the APB port, one 32-bit register every four bytes; write it only
// while the block is idle.
`include "key_repeat_and_char_translate_macros.svh"

module key_repeat_and_char_translate (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  krct_pkg::req_t                req,
	output logic                          req_ready,
	output logic                          rsp_valid,
	output krct_pkg::rsp_t                rsp,
	input  logic                          rsp_ready,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [krct_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	krct_pkg::cfg_t           cfg_q;
	logic                     cmd_valid;
	krct_pkg::cmd_t           cmd;
	logic                     cmd_ready;
	logic                     emit_valid;
	krct_pkg::rsp_t           emit;
	logic                     emit_ready;
	krct_pkg::st_t            st;
	logic [krct_pkg::REG_AW-1:0] reg_idx;

	// register index is the word address
	assign reg_idx = paddr[krct_pkg::REG_AW+1:2];
	assign pready  = 1'b1;

	// configuration writes complete in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_limit       <= krct_pkg::RST_HOLD_LIMIT;
			cfg_q.rpt_period       <= krct_pkg::RST_RPT_PERIOD;
			cfg_q.queue_limit      <= krct_pkg::RST_QUEUE_LIMIT;
			cfg_q.letter_base      <= krct_pkg::RST_LETTER_BASE;
			cfg_q.digit_base       <= krct_pkg::RST_DIGIT_BASE;
			cfg_q.shift_left_code  <= krct_pkg::RST_SHIFT_LEFT;
			cfg_q.shift_right_code <= krct_pkg::RST_SHIFT_RIGHT;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				krct_pkg::REG_HOLD_LIMIT:  cfg_q.hold_limit       <= pwdata;
				krct_pkg::REG_RPT_PERIOD:  cfg_q.rpt_period       <= pwdata;
				krct_pkg::REG_QUEUE_LIMIT: cfg_q.queue_limit      <= pwdata[5:0];
				krct_pkg::REG_LETTER_BASE: cfg_q.letter_base      <= pwdata[7:0];
				krct_pkg::REG_DIGIT_BASE:  cfg_q.digit_base       <= pwdata[7:0];
				krct_pkg::REG_SHIFT_LEFT:  cfg_q.shift_left_code  <= pwdata[7:0];
				krct_pkg::REG_SHIFT_RIGHT: cfg_q.shift_right_code <= pwdata[7:0];
				default: begin
					// drop writes past the register list
				end
			endcase
		end
	end

	// readback, zero-extended
	always_comb begin
		case (reg_idx)
			krct_pkg::REG_HOLD_LIMIT:  prdata = cfg_q.hold_limit;
			krct_pkg::REG_RPT_PERIOD:  prdata = cfg_q.rpt_period;
			krct_pkg::REG_QUEUE_LIMIT: prdata = {26'd0, cfg_q.queue_limit};
			krct_pkg::REG_LETTER_BASE: prdata = {24'd0, cfg_q.letter_base};
			krct_pkg::REG_DIGIT_BASE:  prdata = {24'd0, cfg_q.digit_base};
			krct_pkg::REG_SHIFT_LEFT:  prdata = {24'd0, cfg_q.shift_left_code};
			krct_pkg::REG_SHIFT_RIGHT: prdata = {24'd0, cfg_q.shift_right_code};
			default:                   prdata = '0;
		endcase
	end

	// accept and classify, hold commands until the back end is free
	krct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	// table update, code queue and drain translation
	krct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_ready  (cmd_ready),
		.emit_valid (emit_valid),
		.emit       (emit),
		.emit_ready (emit_ready),
		.st         (st)
	);

	// decouple the back end from rsp stalls
	krct_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.fill_valid (emit_valid),
		.fill       (emit),
		.fill_ready (emit_ready),
		.rsp_valid  (rsp_valid),
		.rsp        (rsp),
		.rsp_ready  (rsp_ready)
	);

	// an empty drain result is always the closing one and carries no character
	`KRCT_ASSERT_IMP(a_empty_is_last, clk, arst_n, rsp_valid && !rsp.char_valid, rsp.last)
	`KRCT_ASSERT_IMP(a_empty_is_zero, clk, arst_n, rsp_valid && !rsp.char_valid, rsp.character == 7'd0)
	// the code queue never holds more than its depth
	`KRCT_ASSERT_IMP(a_queue_bound, clk, arst_n, 1'b1, 32'(st.q_count) <= krct_pkg::QUEUE_DEPTH)
	// a finished drain leaves the queue empty
	`KRCT_ASSERT_NXT(a_drain_empties, clk, arst_n, st.drain_done, st.q_count == '0)

endmodule
